// File: hdl/i2cmbe_pkg.sv
// shared types and constants for the i2c master bit engine
// no dependencies; used by i2c_master_bit_engine_top

package i2cmbe_pkg;

    // field widths
    localparam int KIND_WIDTH = 3;
    localparam int BYTE_WIDTH = 8;
    localparam int CFG_WIDTH  = 16;
    localparam int BIT_WIDTH  = 4;

    // wait length after reset, in ticks
    localparam logic [CFG_WIDTH-1:0] WAIT_TICKS_RESET = 16'd20;

    // bits per byte
    localparam logic [BIT_WIDTH-1:0] BITS_PER_BYTE = 4'd8;

    // item kinds
    localparam logic [KIND_WIDTH-1:0] KIND_TICK      = 3'd0;
    localparam logic [KIND_WIDTH-1:0] KIND_START     = 3'd1;
    localparam logic [KIND_WIDTH-1:0] KIND_STOP      = 3'd2;
    localparam logic [KIND_WIDTH-1:0] KIND_WRITE     = 3'd3;
    localparam logic [KIND_WIDTH-1:0] KIND_READ_ACK  = 3'd4;
    localparam logic [KIND_WIDTH-1:0] KIND_READ_NACK = 3'd5;

    // one result item
    typedef struct packed {
        logic                  scl_out;
        logic                  sda_out;
        logic                  busy_res;
        logic                  read_valid;
        logic [BYTE_WIDTH-1:0] read_byte;
        logic                  rejected;
    } t_result;

endpackage

// File: hdl/i2c_master_bit_engine_top.sv
// i2c master bit engine: pin sequencer, result register and skid stage
// depends on i2cmbe_pkg

// One item (tick or command) is accepted every clock cycle while o_stall is low,
// and its result is registered; the pin sequencer updates its phase, counters and
// shift register per item, so the sustained rate is one item per clock while
// o_stall is low. A result register with a one-entry skid stage separates the
// output from the input: o_stall rises only once a result is held in the skid stage.
// Commands are taken only while idle; a command that arrives while busy is
// flagged as rejected and consumes no time. Each wait phase lasts wait_ticks
// tick items (0 counts as 1, values beyond the counter range saturate); a new
// wait_ticks value applies from the next wait that is loaded.
module i2c_master_bit_engine_top #(
    parameter int WAIT_COUNT_WIDTH = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // item input
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [i2cmbe_pkg::KIND_WIDTH-1:0]  i_kind,
    input  logic [i2cmbe_pkg::BYTE_WIDTH-1:0]  i_data_byte,
    input  logic                               i_sda_level,
    // result output
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic                               o_scl_out,
    output logic                               o_sda_out,
    output logic                               o_busy_res,
    output logic                               o_read_valid,
    output logic [i2cmbe_pkg::BYTE_WIDTH-1:0]  o_read_byte,
    output logic                               o_rejected,
    // configuration write
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [i2cmbe_pkg::CFG_WIDTH-1:0]   i_cfg_data
);

    localparam int CfgW = i2cmbe_pkg::CFG_WIDTH;
    localparam int BitW = i2cmbe_pkg::BIT_WIDTH;
    localparam int ByteW = i2cmbe_pkg::BYTE_WIDTH;

    typedef enum logic [4:0] {
        PH_IDLE, PH_S1, PH_S2, PH_P1, PH_P2, PH_P3,
        PH_W1, PH_W2, PH_W3, PH_W4, PH_W5, PH_W6,
        PH_R1, PH_R2, PH_R3, PH_R4, PH_R5
    } t_phase;

    // state
    t_phase                         r_phase, n_phase;
    logic [i2cmbe_pkg::KIND_WIDTH-1:0] r_operation, n_operation;
    logic [BitW-1:0]                r_bit_index, n_bit_index;
    logic [ByteW-1:0]               r_shift, n_shift;
    logic [WAIT_COUNT_WIDTH-1:0]    r_wait_count, n_wait_count;
    logic                           r_scl, n_scl;
    logic                           r_sda, n_sda;
    logic [CfgW-1:0]                r_wait_ticks;

    // output register and skid stage
    logic                           r_out_valid;
    i2cmbe_pkg::t_result            r_out;
    logic                           r_skid_valid;
    i2cmbe_pkg::t_result            r_skid;

    i2cmbe_pkg::t_result            n_result;
    logic                           in_fire;
    logic                           out_take;
    logic                           is_cmd;
    logic                           done_read;
    logic                           rej;
    logic [WAIT_COUNT_WIDTH-1:0]    w_sat;
    logic [WAIT_COUNT_WIDTH-1:0]    w_load;
    logic [WAIT_COUNT_WIDTH-1:0]    wc_dec;
    logic [BitW-1:0]                bit_inc;

    assign in_fire     = i_valid && !o_stall;
    assign out_take    = r_out_valid && !i_stall;
    assign o_stall     = r_skid_valid;
    assign o_cfg_ready = 1'b1;

    // wait length clamped to the counter range
    generate
        if (WAIT_COUNT_WIDTH >= CfgW) begin : g_wide
            assign w_sat = WAIT_COUNT_WIDTH'(r_wait_ticks);
        end else begin : g_narrow
            assign w_sat = (|r_wait_ticks[CfgW-1:WAIT_COUNT_WIDTH]) ?
                           {WAIT_COUNT_WIDTH{1'b1}} :
                           r_wait_ticks[WAIT_COUNT_WIDTH-1:0];
        end
    endgenerate

    assign w_load  = (w_sat == '0) ? {{(WAIT_COUNT_WIDTH-1){1'b0}}, 1'b1} : w_sat;
    assign wc_dec  = (r_wait_count != '0) ? (r_wait_count - 1'b1) : r_wait_count;
    assign bit_inc = r_bit_index + 1'b1;
    assign is_cmd  = (i_kind >= i2cmbe_pkg::KIND_START) &&
                     (i_kind <= i2cmbe_pkg::KIND_READ_NACK);

    // phase sequencer: next state for the item at the input
    always_comb begin
        n_phase      = r_phase;
        n_operation  = r_operation;
        n_bit_index  = r_bit_index;
        n_shift      = r_shift;
        n_wait_count = r_wait_count;
        n_scl        = r_scl;
        n_sda        = r_sda;
        done_read    = 1'b0;
        rej          = 1'b0;
        if (is_cmd) begin
            if (r_phase != PH_IDLE) begin
                rej = 1'b1;
            end else begin
                // command start
                n_operation  = i_kind;
                n_wait_count = w_load;
                case (i_kind)
                    i2cmbe_pkg::KIND_START: begin
                        n_scl   = 1'b1;
                        n_sda   = 1'b1;
                        n_phase = PH_S1;
                    end
                    i2cmbe_pkg::KIND_STOP: begin
                        n_sda   = 1'b0;
                        n_phase = PH_P1;
                    end
                    i2cmbe_pkg::KIND_WRITE: begin
                        n_bit_index = '0;
                        n_shift     = i_data_byte;
                        n_phase     = PH_W1;
                    end
                    default: begin
                        n_sda       = 1'b1;
                        n_bit_index = '0;
                        n_shift     = '0;
                        n_phase     = PH_R1;
                    end
                endcase
            end
        end else if (r_phase != PH_IDLE) begin
            // tick: count down, step the phase when the wait ends
            n_wait_count = wc_dec;
            if (wc_dec == '0) begin
                case (r_phase)
                    PH_S1: begin
                        n_sda = 1'b0; n_wait_count = w_load; n_phase = PH_S2;
                    end
                    PH_S2: begin
                        n_scl = 1'b0; n_phase = PH_IDLE;
                    end
                    PH_P1: begin
                        n_scl = 1'b1; n_wait_count = w_load; n_phase = PH_P2;
                    end
                    PH_P2: begin
                        n_sda = 1'b1; n_wait_count = w_load; n_phase = PH_P3;
                    end
                    PH_P3: begin
                        n_phase = PH_IDLE;
                    end
                    PH_W1: begin
                        n_sda = r_shift[ByteW-1]; n_wait_count = w_load; n_phase = PH_W2;
                    end
                    PH_W2: begin
                        n_scl        = 1'b1;
                        n_shift      = {r_shift[ByteW-2:0], 1'b0};
                        n_wait_count = w_load;
                        n_phase      = PH_W3;
                    end
                    PH_W3: begin
                        n_scl        = 1'b0;
                        n_bit_index  = bit_inc;
                        n_wait_count = w_load;
                        n_phase      = (bit_inc < i2cmbe_pkg::BITS_PER_BYTE) ? PH_W1 : PH_W4;
                    end
                    PH_W4: begin
                        n_wait_count = w_load; n_phase = PH_W5;
                    end
                    PH_W5: begin
                        n_sda = 1'b1; n_scl = 1'b1; n_wait_count = w_load; n_phase = PH_W6;
                    end
                    PH_W6: begin
                        n_scl = 1'b0; n_sda = 1'b0; n_phase = PH_IDLE;
                    end
                    PH_R1: begin
                        n_scl = 1'b1; n_wait_count = w_load; n_phase = PH_R2;
                    end
                    PH_R2: begin
                        // sample the data line after the clock has been high
                        n_shift      = {r_shift[ByteW-2:0], i_sda_level};
                        n_scl        = 1'b0;
                        n_bit_index  = bit_inc;
                        n_wait_count = w_load;
                        if (bit_inc < i2cmbe_pkg::BITS_PER_BYTE) begin
                            n_phase = PH_R1;
                        end else begin
                            n_sda   = (r_operation == i2cmbe_pkg::KIND_READ_ACK) ? 1'b0 : 1'b1;
                            n_phase = PH_R3;
                        end
                    end
                    PH_R3: begin
                        n_scl = 1'b1; n_wait_count = w_load; n_phase = PH_R4;
                    end
                    PH_R4: begin
                        n_scl = 1'b0; n_wait_count = w_load; n_phase = PH_R5;
                    end
                    PH_R5: begin
                        n_phase = PH_IDLE; done_read = 1'b1;
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase
            end
        end
    end

    // result of the item at the input
    always_comb begin
        n_result.scl_out    = n_scl;
        n_result.sda_out    = n_sda;
        n_result.busy_res   = (n_phase != PH_IDLE);
        n_result.read_valid = done_read;
        n_result.read_byte  = done_read ? n_shift : '0;
        n_result.rejected   = rej;
    end

    // state, configuration and output registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_operation  <= '0;
            r_bit_index  <= '0;
            r_shift      <= '0;
            r_wait_count <= '0;
            r_scl        <= 1'b1;
            r_sda        <= 1'b1;
            r_wait_ticks <= i2cmbe_pkg::WAIT_TICKS_RESET;
            r_out_valid  <= 1'b0;
            r_out        <= '0;
            r_skid_valid <= 1'b0;
            r_skid       <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_wait_ticks <= i_cfg_data;
            end
            if (in_fire) begin
                r_phase      <= n_phase;
                r_operation  <= n_operation;
                r_bit_index  <= n_bit_index;
                r_shift      <= n_shift;
                r_wait_count <= n_wait_count;
                r_scl        <= n_scl;
                r_sda        <= n_sda;
                if (!r_out_valid || out_take) begin
                    r_out       <= n_result;
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid       <= n_result;
                    r_skid_valid <= 1'b1;
                end
            end else if (out_take) begin
                if (r_skid_valid) begin
                    r_out        <= r_skid;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= 1'b0;
                end
            end
        end
    end

    assign o_valid      = r_out_valid;
    assign o_scl_out    = r_out.scl_out;
    assign o_sda_out    = r_out.sda_out;
    assign o_busy_res   = r_out.busy_res;
    assign o_read_valid = r_out.read_valid;
    assign o_read_byte  = r_out.read_byte;
    assign o_rejected   = r_out.rejected;

    // a running sequence always has a wait in progress, idle never does
    a_wait_matches_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE) == (r_wait_count == '0))
        else $error("wait counter out of step with phase");

    // skid stage only fills behind a held result
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid stage full with empty output register");

    // bit counter never passes one byte
    a_bit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit_index <= i2cmbe_pkg::BITS_PER_BYTE)
        else $error("bit counter beyond byte length");

    // a rejected command leaves the sequencer untouched
    a_reject_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && is_cmd && r_phase != PH_IDLE) |=>
            ($stable(r_phase) && $stable(r_wait_count) && $stable(r_shift)))
        else $error("rejected command changed sequencer state");

    // a completed read ends the sequence
    a_read_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.read_valid) |-> (!r_out.busy_res && !r_out.rejected))
        else $error("read completion reported while busy or rejected");

endmodule

// File: sim/tb.sv
// testbench for i2c_master_bit_engine_top: directed and random item traffic
// checked against a cycle-free predictor of the pin sequence
// depends on i2cmbe_pkg and i2c_master_bit_engine_top

module tb;

    // kinds outside the command set behave as ticks
    localparam logic [i2cmbe_pkg::KIND_WIDTH-1:0] KIND_SPARE_LO = 3'd6;
    localparam logic [i2cmbe_pkg::KIND_WIDTH-1:0] KIND_SPARE_HI = 3'd7;

    // how the sampled sda level is chosen during a sequence
    localparam int SDA_LOW    = 0;
    localparam int SDA_HIGH   = 1;
    localparam int SDA_RANDOM = 2;

    // sequencer phases, named after the action taken when the wait runs out
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_START_SDA_LOW,
        ST_START_SCL_LOW,
        ST_STOP_SCL_HIGH,
        ST_STOP_SDA_HIGH,
        ST_STOP_END,
        ST_WR_DRIVE_BIT,
        ST_WR_SCL_HIGH,
        ST_WR_SCL_LOW,
        ST_WR_ACK_WAIT,
        ST_WR_ACK_CLOCK,
        ST_WR_END,
        ST_RD_SCL_HIGH,
        ST_RD_SAMPLE,
        ST_RD_ACK_HIGH,
        ST_RD_ACK_LOW,
        ST_RD_END
    } t_bus_phase;

    logic                                 i_clk = 1'b0;
    logic                                 i_rst_n = 1'b0;
    logic                                 i_valid = 1'b0;
    logic                                 o_stall;
    logic [i2cmbe_pkg::KIND_WIDTH-1:0]    i_kind = i2cmbe_pkg::KIND_TICK;
    logic [i2cmbe_pkg::BYTE_WIDTH-1:0]    i_data_byte = '0;
    logic                                 i_sda_level = 1'b1;
    logic                                 o_valid;
    logic                                 i_stall = 1'b0;
    logic                                 o_scl_out;
    logic                                 o_sda_out;
    logic                                 o_busy_res;
    logic                                 o_read_valid;
    logic [i2cmbe_pkg::BYTE_WIDTH-1:0]    o_read_byte;
    logic                                 o_rejected;
    logic                                 i_cfg_valid = 1'b0;
    logic                                 o_cfg_ready;
    logic [i2cmbe_pkg::CFG_WIDTH-1:0]     i_cfg_data = '0;

    // predicted sequencer state
    t_bus_phase                           bus_phase = ST_IDLE;
    logic [i2cmbe_pkg::KIND_WIDTH-1:0]    bus_op = '0;
    logic [i2cmbe_pkg::BIT_WIDTH-1:0]     bit_count = '0;
    logic [i2cmbe_pkg::BYTE_WIDTH-1:0]    shift_reg = '0;
    logic [i2cmbe_pkg::CFG_WIDTH-1:0]     wait_left = '0;
    logic                                 scl_level = 1'b1;
    logic                                 sda_drive = 1'b1;
    logic [i2cmbe_pkg::CFG_WIDTH-1:0]     wait_len = i2cmbe_pkg::WAIT_TICKS_RESET;

    i2cmbe_pkg::t_result pending_pins[$];
    int unsigned items_sent = 0;
    int unsigned fail_count = 0;
    int unsigned gap_pct = 0;
    int unsigned stall_pct = 0;

    i2c_master_bit_engine_top i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_kind       (i_kind),
        .i_data_byte  (i_data_byte),
        .i_sda_level  (i_sda_level),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_scl_out    (o_scl_out),
        .o_sda_out    (o_sda_out),
        .o_busy_res   (o_busy_res),
        .o_read_valid (o_read_valid),
        .o_read_byte  (o_read_byte),
        .o_rejected   (o_rejected),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // start a wait phase; a zero length counts as one tick
    function automatic void load_wait(input t_bus_phase next_phase);
        wait_left = (wait_len == '0) ? 16'd1 : wait_len;
        bus_phase = next_phase;
    endfunction

    // pin levels and read byte after one item
    function automatic i2cmbe_pkg::t_result predict_pins(
        input logic [i2cmbe_pkg::KIND_WIDTH-1:0] kind,
        input logic [i2cmbe_pkg::BYTE_WIDTH-1:0] data,
        input logic sda);
        i2cmbe_pkg::t_result r;
        logic                read_done;
        r = '0;
        read_done = 1'b0;
        if (kind >= i2cmbe_pkg::KIND_START && kind <= i2cmbe_pkg::KIND_READ_NACK) begin
            // commands only start from idle
            if (bus_phase != ST_IDLE) begin
                r.rejected = 1'b1;
            end else begin
                bus_op = kind;
                case (kind)
                    i2cmbe_pkg::KIND_START: begin
                        scl_level = 1'b1;
                        sda_drive = 1'b1;
                        load_wait(ST_START_SDA_LOW);
                    end
                    i2cmbe_pkg::KIND_STOP: begin
                        sda_drive = 1'b0;
                        load_wait(ST_STOP_SCL_HIGH);
                    end
                    i2cmbe_pkg::KIND_WRITE: begin
                        bit_count = '0;
                        shift_reg = data;
                        load_wait(ST_WR_DRIVE_BIT);
                    end
                    default: begin
                        sda_drive = 1'b1;
                        bit_count = '0;
                        shift_reg = '0;
                        load_wait(ST_RD_SCL_HIGH);
                    end
                endcase
            end
        end else if (bus_phase != ST_IDLE) begin
            // a tick counts the wait down and acts when it runs out
            if (wait_left != '0) wait_left = wait_left - 16'd1;
            if (wait_left == '0) begin
                case (bus_phase)
                    ST_START_SDA_LOW: begin
                        sda_drive = 1'b0;
                        load_wait(ST_START_SCL_LOW);
                    end
                    ST_START_SCL_LOW: begin
                        scl_level = 1'b0;
                        bus_phase = ST_IDLE;
                    end
                    ST_STOP_SCL_HIGH: begin
                        scl_level = 1'b1;
                        load_wait(ST_STOP_SDA_HIGH);
                    end
                    ST_STOP_SDA_HIGH: begin
                        sda_drive = 1'b1;
                        load_wait(ST_STOP_END);
                    end
                    ST_WR_DRIVE_BIT: begin
                        sda_drive = shift_reg[7];
                        load_wait(ST_WR_SCL_HIGH);
                    end
                    ST_WR_SCL_HIGH: begin
                        scl_level = 1'b1;
                        shift_reg = shift_reg << 1;
                        load_wait(ST_WR_SCL_LOW);
                    end
                    ST_WR_SCL_LOW: begin
                        scl_level = 1'b0;
                        bit_count = bit_count + 4'd1;
                        load_wait(bit_count < i2cmbe_pkg::BITS_PER_BYTE ?
                                  ST_WR_DRIVE_BIT : ST_WR_ACK_WAIT);
                    end
                    ST_WR_ACK_WAIT: begin
                        load_wait(ST_WR_ACK_CLOCK);
                    end
                    ST_WR_ACK_CLOCK: begin
                        sda_drive = 1'b1;
                        scl_level = 1'b1;
                        load_wait(ST_WR_END);
                    end
                    ST_WR_END: begin
                        scl_level = 1'b0;
                        sda_drive = 1'b0;
                        bus_phase = ST_IDLE;
                    end
                    ST_RD_SCL_HIGH: begin
                        scl_level = 1'b1;
                        load_wait(ST_RD_SAMPLE);
                    end
                    ST_RD_SAMPLE: begin
                        shift_reg = {shift_reg[6:0], sda};
                        scl_level = 1'b0;
                        bit_count = bit_count + 4'd1;
                        if (bit_count < i2cmbe_pkg::BITS_PER_BYTE) begin
                            load_wait(ST_RD_SCL_HIGH);
                        end else begin
                            sda_drive = (bus_op == i2cmbe_pkg::KIND_READ_ACK) ? 1'b0 : 1'b1;
                            load_wait(ST_RD_ACK_HIGH);
                        end
                    end
                    ST_RD_ACK_HIGH: begin
                        scl_level = 1'b1;
                        load_wait(ST_RD_ACK_LOW);
                    end
                    ST_RD_ACK_LOW: begin
                        scl_level = 1'b0;
                        load_wait(ST_RD_END);
                    end
                    ST_RD_END: begin
                        bus_phase = ST_IDLE;
                        read_done = 1'b1;
                    end
                    default: begin
                        bus_phase = ST_IDLE;
                    end
                endcase
            end
        end
        r.scl_out    = scl_level;
        r.sda_out    = sda_drive;
        r.busy_res   = (bus_phase != ST_IDLE);
        r.read_valid = read_done;
        r.read_byte  = read_done ? shift_reg : '0;
        return r;
    endfunction

    function automatic logic [i2cmbe_pkg::KIND_WIDTH-1:0] filler_kind();
        case ($urandom_range(3))
            0: return KIND_SPARE_LO;
            1: return KIND_SPARE_HI;
            default: return i2cmbe_pkg::KIND_TICK;
        endcase
    endfunction

    function automatic logic sda_pick(input int mode);
        if (mode == SDA_LOW) return 1'b0;
        if (mode == SDA_HIGH) return 1'b1;
        return 1'($urandom_range(1));
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $error("%s expected %0d actual %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // one item transfer, with an optional idle gap before it
    task automatic send_item(input logic [i2cmbe_pkg::KIND_WIDTH-1:0] kind,
                             input logic [i2cmbe_pkg::BYTE_WIDTH-1:0] data,
                             input logic sda);
        if ($urandom_range(99) < gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < gap_pct) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_kind      <= kind;
        i_data_byte <= data;
        i_sda_level <= sda;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        // ticks while idle do nothing and are not counted
        if (bus_phase != ST_IDLE ||
            (kind >= i2cmbe_pkg::KIND_START && kind <= i2cmbe_pkg::KIND_READ_NACK))
            items_sent++;
        pending_pins.push_back(predict_pins(kind, data, sda));
    endtask

    // ticks until the sequence ends, with some rejected commands and spare kinds
    task automatic finish_sequence(input int unsigned noise_pct, input int sda_mode);
        int unsigned pick;
        while (bus_phase != ST_IDLE) begin
            pick = $urandom_range(99);
            if (pick < noise_pct)
                send_item(i2cmbe_pkg::KIND_START + 3'($urandom_range(4)), 8'($urandom),
                          sda_pick(sda_mode));
            else
                send_item(pick < 2 * noise_pct ? filler_kind() : i2cmbe_pkg::KIND_TICK,
                          8'($urandom), sda_pick(sda_mode));
        end
    endtask

    task automatic run_command(input logic [i2cmbe_pkg::KIND_WIDTH-1:0] kind,
                               input logic [i2cmbe_pkg::BYTE_WIDTH-1:0] data,
                               input int unsigned noise_pct, input int sda_mode);
        send_item(kind, data, sda_pick(sda_mode));
        finish_sequence(noise_pct, sda_mode);
    endtask

    // hold the sender until every result has been checked
    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_pins.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_wait_ticks(input logic [i2cmbe_pkg::CFG_WIDTH-1:0] value);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        wait_len = value;
    endtask

    task automatic test_idle_ticks();
        send_item(i2cmbe_pkg::KIND_TICK, 8'h00, 1'b0);
        send_item(i2cmbe_pkg::KIND_TICK, 8'hFF, 1'b1);
        send_item(KIND_SPARE_LO, 8'h5A, 1'b0);
        send_item(KIND_SPARE_HI, 8'hA5, 1'b1);
    endtask

    // start on the wait length from reset, stop on the shortest wait
    task automatic test_start_stop();
        run_command(i2cmbe_pkg::KIND_START, 8'h00, 0, SDA_RANDOM);
        write_wait_ticks(16'd1);
        run_command(i2cmbe_pkg::KIND_STOP, 8'hFF, 0, SDA_RANDOM);
    endtask

    task automatic test_write_extremes();
        run_command(i2cmbe_pkg::KIND_WRITE, 8'h00, 0, SDA_LOW);
        run_command(i2cmbe_pkg::KIND_WRITE, 8'hFF, 0, SDA_HIGH);
        run_command(i2cmbe_pkg::KIND_WRITE, 8'hA5, 0, SDA_RANDOM);
    endtask

    task automatic test_reads();
        run_command(i2cmbe_pkg::KIND_READ_ACK, 8'h00, 0, SDA_HIGH);
        run_command(i2cmbe_pkg::KIND_READ_NACK, 8'hFF, 0, SDA_LOW);
        run_command(i2cmbe_pkg::KIND_READ_ACK, 8'h00, 0, SDA_RANDOM);
        run_command(i2cmbe_pkg::KIND_READ_NACK, 8'h00, 0, SDA_RANDOM);
    endtask

    // every command is refused while a sequence is running
    task automatic test_busy_commands();
        send_item(i2cmbe_pkg::KIND_WRITE, 8'h3C, 1'b0);
        for (int k = i2cmbe_pkg::KIND_START; k <= i2cmbe_pkg::KIND_READ_NACK; k++)
            send_item(i2cmbe_pkg::KIND_WIDTH'(k), 8'hFF, 1'b1);
        finish_sequence(0, SDA_RANDOM);
    endtask

    task automatic test_zero_wait();
        write_wait_ticks(16'd0);
        run_command(i2cmbe_pkg::KIND_WRITE, 8'($urandom), 0, SDA_RANDOM);
        run_command(i2cmbe_pkg::KIND_READ_NACK, 8'h00, 0, SDA_RANDOM);
    endtask

    // longest wait: the start sequence is left running at the end of the run
    task automatic test_long_wait();
        write_wait_ticks(16'hFFFF);
        send_item(i2cmbe_pkg::KIND_START, 8'h00, 1'b1);
        repeat (16) send_item(i2cmbe_pkg::KIND_TICK, 8'($urandom), 1'($urandom_range(1)));
        send_item(i2cmbe_pkg::KIND_WRITE, 8'h81, 1'b0);
        send_item(i2cmbe_pkg::KIND_TICK, 8'h00, 1'b0);
    endtask

    task automatic test_random_traffic(input int unsigned gap, input int unsigned stall,
                                       input logic [i2cmbe_pkg::CFG_WIDTH-1:0] wait_value,
                                       input int unsigned item_goal);
        int unsigned goal_end;
        write_wait_ticks(wait_value);
        gap_pct   = gap;
        stall_pct = stall;
        goal_end  = items_sent + item_goal;
        while (items_sent < goal_end) begin
            if ($urandom_range(99) < 15)
                send_item(filler_kind(), 8'($urandom), 1'($urandom_range(1)));
            run_command(i2cmbe_pkg::KIND_START + 3'($urandom_range(4)), 8'($urandom), 4,
                        SDA_RANDOM);
        end
    endtask

    // result side: random stall and field-by-field compare
    always @(posedge i_clk) begin
        i2cmbe_pkg::t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_pins.size() == 0) begin
                $error("result transfer with no expectation waiting");
                fail_count++;
            end else begin
                want = pending_pins.pop_front();
                check_field("scl_out", 8'(want.scl_out), 8'(o_scl_out));
                check_field("sda_out", 8'(want.sda_out), 8'(o_sda_out));
                check_field("busy_res", 8'(want.busy_res), 8'(o_busy_res));
                check_field("read_valid", 8'(want.read_valid), 8'(o_read_valid));
                check_field("read_byte", want.read_byte, o_read_byte);
                check_field("rejected", 8'(want.rejected), 8'(o_rejected));
            end
        end
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_idle_ticks();
        test_start_stop();
        write_wait_ticks(16'd1);
        test_write_extremes();
        test_reads();
        test_busy_commands();
        test_zero_wait();

        test_random_traffic(0, 0, 16'd1, 20);
        test_random_traffic(86, 0, 16'd2, 20);
        test_random_traffic(0, 86, 16'd3, 20);
        test_random_traffic(32, 32, 16'd1, 20);

        test_long_wait();

        drain_results();
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // run limit
    initial begin
        #40_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

// File: i2c_master_bit_engine_top.f
hdl/i2cmbe_pkg.sv
hdl/i2c_master_bit_engine_top.sv
sim/tb.sv
